[src/xor_checked_frame_deframer_defines.svh]
// Assertion macros for the frame deframer checker.
`ifndef XOR_CHECKED_FRAME_DEFRAMER_DEFINES_SVH
`define XOR_CHECKED_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define XCFD_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define XCFD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/xcfd_pkg.sv]
// Shared types and codes for the frame deframer.
package xcfd_pkg;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_GOOD = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	localparam int unsigned MARK_W   = 16;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 32;
	localparam int unsigned HDR_LAST = 4;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [BYTE_W-1:0] command;
		logic [BYTE_W-1:0] data_byte;
		logic              last;
	} res_t;

endpackage

[src/xcfd_in_stage.sv]
// Input register stage: captures one received byte per beat.
module xcfd_in_stage import xcfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,
	input  logic              advance,
	output logic              valid_s1,
	output logic [BYTE_W-1:0] byte_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

[src/xcfd_parser.sv]
// Frame parser: mark hunt, header, payload and checksum state machine.
module xcfd_parser import xcfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [MARK_W-1:0] start_mark,
	output res_t              res
);

	typedef enum logic [2:0] {
		HUNT_EMPTY = 3'd0,
		HUNT_HELD  = 3'd1,
		HEADER     = 3'd2,
		PAYLOAD    = 3'd3,
		CHECK_HI   = 3'd4,
		CHECK_LO   = 3'd5
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] prev_q, prev_d;
	logic [2:0]        hidx_q, hidx_d;
	logic [BYTE_W-1:0] cmd_q, cmd_d;
	logic [LEN_W-1:0]  rem_q, rem_d;
	logic [BYTE_W-1:0] xor_q, xor_d;
	logic [BYTE_W-1:0] chk_q, chk_d;
	res_t              res_c;

	always_comb begin
		phase_d = phase_q;
		prev_d  = prev_q;
		hidx_d  = hidx_q;
		cmd_d   = cmd_q;
		rem_d   = rem_q;
		xor_d   = xor_q;
		chk_d   = chk_q;
		res_c   = '{valid: 1'b0, kind: KIND_DATA, command: cmd_q,
			data_byte: '0, last: 1'b0};
		unique case (phase_q)
			HUNT_EMPTY: begin
				prev_d  = rx_byte;
				phase_d = HUNT_HELD;
			end
			HUNT_HELD: begin
				if ({prev_q, rx_byte} == start_mark) begin
					xor_d   = prev_q ^ rx_byte;
					hidx_d  = '0;
					rem_d   = '0;
					phase_d = HEADER;
				end else begin
					prev_d = rx_byte;
				end
			end
			HEADER: begin
				xor_d = xor_q ^ rx_byte;
				if (hidx_q == '0) begin
					cmd_d = rx_byte;
				end else begin
					rem_d = {rem_q[LEN_W-BYTE_W-1:0], rx_byte};
				end
				if (hidx_q == 3'(HDR_LAST)) begin
					hidx_d  = '0;
					phase_d = (rem_d != '0) ? PAYLOAD : CHECK_HI;
				end else begin
					hidx_d = hidx_q + 3'd1;
				end
			end
			PAYLOAD: begin
				xor_d = xor_q ^ rx_byte;
				rem_d = rem_q - LEN_W'(1);
				if (rem_q == LEN_W'(1)) begin
					phase_d = CHECK_HI;
				end
				res_c.valid     = 1'b1;
				res_c.kind      = KIND_DATA;
				res_c.data_byte = rx_byte;
			end
			CHECK_HI: begin
				chk_d   = rx_byte;
				phase_d = CHECK_LO;
			end
			CHECK_LO: begin
				res_c.valid = 1'b1;
				res_c.last  = 1'b1;
				res_c.kind  = ((chk_q == '0) && (rx_byte == xor_q)) ? KIND_GOOD : KIND_BAD;
				phase_d = HUNT_EMPTY;
				prev_d  = '0;
				hidx_d  = '0;
				rem_d   = '0;
				xor_d   = '0;
				chk_d   = '0;
			end
			default: begin
				prev_d  = rx_byte;
				phase_d = HUNT_HELD;
			end
		endcase
	end

	assign res = step ? res_c : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= HUNT_EMPTY;
			prev_q  <= '0;
			hidx_q  <= '0;
			cmd_q   <= '0;
			rem_q   <= '0;
			xor_q   <= '0;
			chk_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			prev_q  <= prev_d;
			hidx_q  <= hidx_d;
			cmd_q   <= cmd_d;
			rem_q   <= rem_d;
			xor_q   <= xor_d;
			chk_q   <= chk_d;
		end
	end

endmodule

[src/xcfd_out_stage.sv]
// Result register stage driving the master-side stream.
module xcfd_out_stage import xcfd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  res_t                res,
	output logic                ready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [2*BYTE_W-1:0] m_tdata,
	output logic [1:0]          m_tuser,
	output logic                m_tlast
);

	logic              valid_q;
	kind_t             kind_q;
	logic [BYTE_W-1:0] cmd_q;
	logic [BYTE_W-1:0] data_q;
	logic              last_q;

	assign ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && res.valid) begin
			kind_q <= res.kind;
			cmd_q  <= res.command;
			data_q <= res.data_byte;
			last_q <= res.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {data_q, cmd_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

[src/xor_checked_frame_deframer.sv]
// Top level of the XOR-checked frame deframer.
// Takes one received byte per beat, sustained at one byte per clock while the master side
// takes its results; each byte passes an input register, the combinational parser logic
// and the result register, from which a payload byte or verdict reaches the master side.
// s_tready falls only while a result sits in the output register unclaimed. The
// start mark is written on cfg_we and is compared whenever the parser hunts for a mark.
module xor_checked_frame_deframer import xcfd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [MARK_W-1:0]   cfg_wdata,  // start_mark
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [BYTE_W-1:0]   s_tdata,    // [7:0] rx_byte
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [2*BYTE_W-1:0] m_tdata,    // [7:0] command, [15:8] data_byte
	output logic [1:0]          m_tuser,    // [1:0] kind
	output logic                m_tlast     // last
);

	logic [MARK_W-1:0] start_mark_q;
	logic              advance;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	res_t              res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_mark_q <= '0;
		end else if (cfg_we) begin
			start_mark_q <= cfg_wdata;
		end
	end

	xcfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	xcfd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (valid_s1 && advance),
		.rx_byte    (byte_s1),
		.start_mark (start_mark_q),
		.res        (res)
	);

	xcfd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.ready    (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[src/xcfd_checker.sv]
// Port-level assertion checker for the frame deframer, bound to the top level.
`include "xor_checked_frame_deframer_defines.svh"

module xcfd_checker import xcfd_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [2*BYTE_W-1:0] m_tdata,
	input logic [1:0]          m_tuser,
	input logic                m_tlast
);

	`XCFD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled beat changed")
	`XCFD_ASSERT_NOW(a_verdict_shape, clk, arst_n, m_tvalid && m_tlast, (m_tuser == KIND_GOOD || m_tuser == KIND_BAD) && m_tdata[2*BYTE_W-1:BYTE_W] == '0, "bad verdict beat")
	`XCFD_ASSERT_NOW(a_payload_kind, clk, arst_n, m_tvalid && !m_tlast, m_tuser == KIND_DATA, "payload beat kind wrong")
	`XCFD_ASSERT_NOW(a_ready_stall, clk, arst_n, !s_tready, m_tvalid && !m_tready, "input stalled without output stall")

endmodule

bind xor_checked_frame_deframer xcfd_checker u_xcfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the XOR-checked frame deframer, with a bytewise stream model.
module testbench;
	import xcfd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE_HUNT,
		ST_MARK_HUNT,
		ST_HEADER,
		ST_BODY,
		ST_SUM_HI,
		ST_SUM_LO
	} parse_state_t;

	typedef enum int {
		FLAW_NONE,
		FLAW_CK_LOW,
		FLAW_CK_HIGH,
		FLAW_SHORT
	} frame_flaw_t;

	typedef enum int {
		RDY_ALWAYS,
		RDY_RANDOM,
		RDY_PERIODIC,
		RDY_SPARSE
	} sink_mode_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] command;
		logic [7:0] data_byte;
		logic       last;
	} frame_beat_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [MARK_W-1:0]   cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [BYTE_W-1:0]   s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [2*BYTE_W-1:0] m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	// stream model state
	parse_state_t pr_phase   = ST_IDLE_HUNT;
	logic [15:0]  pr_mark    = '0;
	logic [7:0]   pr_prev    = '0;
	logic [2:0]   pr_hdr_idx = '0;
	logic [7:0]   pr_cmd     = '0;
	logic [31:0]  pr_left    = '0;
	logic [7:0]   pr_xor     = '0;
	logic [7:0]   pr_sum_hi  = '0;

	frame_beat_t pending_beats[$];

	int         n_errors   = 0;
	int         n_sent     = 0;
	int         n_marks    = 0;
	int         n_data     = 0;
	int         n_good     = 0;
	int         n_bad      = 0;
	int         burst_left = 0;
	bit         pace_on    = 0;
	int         sink_cyc   = 0;
	sink_mode_t sink_mode  = RDY_ALWAYS;

	xor_checked_frame_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic void parse_byte(input logic [7:0] b);
		frame_beat_t beat;
		case (pr_phase)
			ST_IDLE_HUNT: begin
				pr_prev  = b;
				pr_phase = ST_MARK_HUNT;
			end
			ST_MARK_HUNT: begin
				if ({pr_prev, b} == pr_mark) begin
					pr_xor     = pr_prev ^ b;
					pr_hdr_idx = '0;
					pr_left    = '0;
					pr_phase   = ST_HEADER;
				end else begin
					pr_prev = b;
				end
			end
			ST_HEADER: begin
				pr_xor ^= b;
				if (pr_hdr_idx == 0)
					pr_cmd = b;
				else
					pr_left = {pr_left[23:0], b};
				if (pr_hdr_idx == HDR_LAST) begin
					pr_hdr_idx = '0;
					pr_phase   = (pr_left != 0) ? ST_BODY : ST_SUM_HI;
				end else begin
					pr_hdr_idx++;
				end
			end
			ST_BODY: begin
				pr_xor ^= b;
				pr_left--;
				if (pr_left == 0)
					pr_phase = ST_SUM_HI;
				beat = '{KIND_DATA, pr_cmd, b, 1'b0};
				pending_beats.push_back(beat);
			end
			ST_SUM_HI: begin
				pr_sum_hi = b;
				pr_phase  = ST_SUM_LO;
			end
			ST_SUM_LO: begin
				beat.kind      = (pr_sum_hi == 0 && b == pr_xor) ? KIND_GOOD : KIND_BAD;
				beat.command   = pr_cmd;
				beat.data_byte = '0;
				beat.last      = 1'b1;
				pending_beats.push_back(beat);
				pr_prev    = '0;
				pr_hdr_idx = '0;
				pr_left    = '0;
				pr_xor     = '0;
				pr_sum_hi  = '0;
				pr_phase   = ST_IDLE_HUNT;
			end
			default: pr_phase = ST_IDLE_HUNT;
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		n_errors++;
		if (n_errors <= 30)
			$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// sink stall pattern, with the stall mode reshuffled at random
	always @(posedge clk) begin
		sink_cyc++;
		if (sink_cyc % 150 == 0)
			sink_mode = sink_mode_t'($urandom_range(0, 3));
		case (sink_mode)
			RDY_ALWAYS:   m_tready <= 1'b1;
			RDY_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
			RDY_PERIODIC: m_tready <= (sink_cyc % 5 < 2);
			default:      m_tready <= ($urandom_range(0, 9) < 2);
		endcase
	end

	always @(posedge clk) begin : check_results
		frame_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat kind %0d cmd %02h data %02h last %0b",
					m_tuser, m_tdata[7:0], m_tdata[15:8], m_tlast));
			end else begin
				want = pending_beats.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
				if (m_tdata[7:0] !== want.command)
					report_mismatch($sformatf("command %02h, expected %02h",
						m_tdata[7:0], want.command));
				if (m_tdata[15:8] !== want.data_byte)
					report_mismatch($sformatf("data_byte %02h, expected %02h",
						m_tdata[15:8], want.data_byte));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b", m_tlast, want.last));
				case (want.kind)
					KIND_DATA: n_data++;
					KIND_GOOD: n_good++;
					default:   n_bad++;
				endcase
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (pace_on) begin
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				burst_left = $urandom_range(1, 40);
			end else begin
				burst_left--;
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		parse_byte(b);
		n_sent++;
	endtask

	// source holds off until every predicted beat is out and the pipe has drained
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mark(input logic [15:0] mk);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= mk;
		@(posedge clk);
		cfg_we  <= 1'b0;
		pr_mark = mk;
		n_marks++;
	endtask

	task automatic build_frame(input logic [15:0] mk, input logic [7:0] cmd,
			input int unsigned len, input frame_flaw_t flaw, ref logic [7:0] q[$]);
		logic [7:0]  x;
		logic [31:0] lw;
		int unsigned keep;
		lw = len;
		q.delete();
		q.push_back(mk[15:8]);
		q.push_back(mk[7:0]);
		q.push_back(cmd);
		for (int i = 3; i >= 0; i--)
			q.push_back(lw[8*i +: 8]);
		keep = (flaw == FLAW_SHORT && len > 0) ? len - $urandom_range(1, len) : len;
		repeat (keep) q.push_back(8'($urandom_range(0, 255)));
		x = '0;
		foreach (q[i])
			x ^= q[i];
		q.push_back((flaw == FLAW_CK_HIGH) ? 8'($urandom_range(1, 255)) : 8'h00);
		q.push_back((flaw == FLAW_CK_LOW) ? x ^ 8'($urandom_range(1, 255)) : x);
	endtask

	task automatic send_frame(input logic [15:0] mk, input logic [7:0] cmd,
			input int unsigned len, input frame_flaw_t flaw);
		logic [7:0] q[$];
		build_frame(mk, cmd, len, flaw, q);
		foreach (q[i])
			send_byte(q[i]);
	endtask

	// reset mark of zero; the first byte is only held, the second completes the mark
	task automatic test_reset_mark();
		send_frame(16'h0000, 8'hA5, 2, FLAW_NONE);
	endtask

	task automatic test_verdicts();
		write_mark(16'hFFFF);
		send_frame(16'hFFFF, 8'h00, 0, FLAW_NONE);
		send_frame(16'hFFFF, 8'hFF, 1, FLAW_CK_LOW);
		send_frame(16'hFFFF, 8'h77, 2, FLAW_CK_HIGH);
	endtask

	task automatic test_hunting();
		write_mark(16'h0042);
		send_frame(16'h0042, 8'h11, 1, FLAW_NONE);
		// lone low byte after a verdict must not match against a zero hold
		send_byte(8'h42);
		send_frame(16'h0042, 8'h22, 0, FLAW_NONE);
		write_mark(16'h1234);
		send_byte(8'h12);
		send_byte(8'h99);
		send_byte(8'h12);
		send_frame(16'h1234, 8'h33, 1, FLAW_NONE);
	endtask

	task automatic test_mark_change_mid_frame();
		logic [7:0] q[$];
		build_frame(16'hFFFF, 8'h3C, 3, FLAW_NONE, q);
		write_mark(16'hFFFF);
		for (int i = 0; i < 5; i++)
			send_byte(q[i]);
		write_mark(16'h0001);
		for (int i = 5; i < q.size(); i++)
			send_byte(q[i]);
		send_frame(16'h0001, 8'h81, 0, FLAW_CK_LOW);
	endtask

	task automatic test_random_traffic();
		logic [15:0] marks[6];
		logic [15:0] mk;
		logic [7:0]  b;
		int          start;
		int          pick;
		int unsigned len;
		frame_flaw_t flaw;
		marks[0] = 16'hFFFF;
		marks[1] = 16'h0000;
		marks[2] = 16'($urandom_range(0, 65535));
		marks[3] = 16'h8001;
		marks[4] = 16'($urandom_range(0, 65535));
		marks[5] = 16'($urandom_range(0, 65535));
		pace_on = 1;
		foreach (marks[p]) begin
			mk = marks[p];
			write_mark(mk);
			start = n_sent;
			while (n_sent - start < 240) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					repeat ($urandom_range(1, 4)) begin
						do b = 8'($urandom_range(0, 255)); while (b == mk[15:8]);
						send_byte(b);
					end
				end else if (pick < 14) begin
					send_byte(mk[15:8]);
					do b = 8'($urandom_range(0, 255)); while (b == mk[7:0] || b == mk[15:8]);
					send_byte(b);
				end else begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 48)
						: $urandom_range(0, 10);
					pick = $urandom_range(0, 99);
					if (pick < 70)
						flaw = FLAW_NONE;
					else if (pick < 82)
						flaw = FLAW_CK_LOW;
					else if (pick < 90)
						flaw = FLAW_CK_HIGH;
					else if (len > 0 && mk[15:8] != 0 && mk[7:0] != 0)
						flaw = FLAW_SHORT;
					else
						flaw = FLAW_NONE;
					send_frame(mk, 8'($urandom_range(0, 255)), len, flaw);
				end
			end
		end
	endtask

	// all-ones length keeps the block in the payload to the end of the run
	task automatic test_full_length();
		write_mark(16'hC3A5);
		send_byte(8'hC3);
		send_byte(8'hA5);
		send_byte(8'h5A);
		repeat (4) send_byte(8'hFF);
		repeat (150) send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_mark();
		test_verdicts();
		test_hunting();
		test_mark_change_mid_frame();
		test_random_traffic();
		test_full_length();

		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d stream bytes across %0d start mark settings,",
			n_sent, n_marks + 1);
		$display("with source gaps and sink stalls; checked %0d payload beats,",
			n_data);
		$display("%0d good frames and %0d checksum mismatches.", n_good, n_bad);
		if (n_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
